/* hdl/ffba_pkg.sv */
// shared types, constants and codes for the first-fit block allocator
// used by every module under hdl except ffba_ram; no dependencies
`default_nettype none

package ffba_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int MAX_BLOCKS   = 64;
    localparam int CHUNK_BYTES  = 65536;
    localparam int PAGE_BYTES   = 4096;
    localparam int ALIGN_BYTES  = 16;
    localparam int HEADER_BYTES = 32;

    localparam int OFF_W  = 20;
    localparam int SIZE_W = 21;
    localparam int REQ_W  = 21;
    localparam int STAT_W = 2;
    localparam int NEED_W = 22;
    localparam int WIDE_W = 26;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int PTR_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic [PTR_W-1:0] NIL      = PTR_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOM     = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic [PTR_W-1:0]  next;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_WALK_RD, S_WALK_CHK, S_NEW_SCAN, S_TAIL_RD, S_TAIL_CHK,
        S_SPLIT_CHK, S_SPLIT_SCAN, S_SPLIT_W2, S_GRANT,
        S_LOOK_RD, S_LOOK_CHK, S_FWD, S_FWD_CHK, S_BWD, S_BWD_CHK, S_BWD_END,
        S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_RES_IGNORED, OP_RES_OOM, OP_RES_UNKNOWN,
        OP_WALK_RD, OP_WALK_NEXT, OP_WALK_HIT,
        OP_SCAN_START, OP_SCAN_STEP, OP_NEW_CHUNK,
        OP_TAIL_RD, OP_TAIL_NEXT, OP_TAIL_LINK,
        OP_SPLIT_W1, OP_SPLIT_W2, OP_GRANT,
        OP_LOOK_RD, OP_LOOK_NEXT, OP_LOOK_HIT,
        OP_FWD_RD, OP_FWD_MERGE,
        OP_BWD_INIT, OP_BWD_RD, OP_BWD_NEXT, OP_BWD_MERGE,
        OP_RES_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_free;
        logic req_zero;
        logic addr_null;
        logic cur_end;
        logic fit;
        logic scan_hit;
        logic scan_last;
        logic new_ok;
        logic head_nil;
        logic tail_more;
        logic split_ok;
        logic look_hit;
        logic look_last;
        logic fwd_stop;
        logic fwd_touch;
        logic bwd_stop;
        logic bwd_merge;
        logic can_load;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/ffba_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/ffba_datapath.sv */
// allocator datapath: block table ram, flag vectors, walk registers, result regs
// depends on ffba_pkg and ffba_ram
`default_nettype none

module ffba_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffba_pkg::t_dp_cmd             i_cmd,
    output ffba_pkg::t_dp_stat                 o_stat,
    input  wire logic                          i_command,
    input  wire logic [ffba_pkg::REQ_W-1:0]    i_request_bytes,
    input  wire logic [ffba_pkg::OFF_W-1:0]    i_free_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [ffba_pkg::OFF_W-1:0]    o_payload_address,
    output logic      [ffba_pkg::STAT_W-1:0]   o_status
);

    localparam int WW = ffba_pkg::WIDE_W;
    localparam logic [WW-1:0] W_HDR   = WW'(ffba_pkg::HEADER_BYTES);
    localparam logic [WW-1:0] W_ALIGN = WW'(ffba_pkg::ALIGN_BYTES);
    localparam logic [WW-1:0] W_PAGEM = WW'(ffba_pkg::PAGE_BYTES - 1);
    localparam logic [WW-1:0] W_CHUNK = WW'(ffba_pkg::CHUNK_BYTES);
    localparam logic [WW-1:0] W_HEAP  = WW'(ffba_pkg::HEAP_BYTES);
    localparam logic [ffba_pkg::NEED_W-1:0] N_ALIGNM =
        ffba_pkg::NEED_W'(ffba_pkg::ALIGN_BYTES - 1);

    logic [ffba_pkg::MAX_BLOCKS-1:0] r_in_use, r_is_free, r_starts;
    logic [ffba_pkg::PTR_W-1:0]      r_head, r_cur, r_prev, r_tail, r_steps;
    logic [ffba_pkg::SIZE_W-1:0]     r_top;
    logic [ffba_pkg::IDX_W-1:0]      r_i, r_blk;
    logic [ffba_pkg::NEED_W-1:0]     r_need;
    logic [ffba_pkg::OFF_W-1:0]      r_addr, r_res_addr;
    logic [ffba_pkg::STAT_W-1:0]     r_res_status;
    logic                            r_cmd, r_req_zero, r_out_valid;
    logic [ffba_pkg::OFF_W-1:0]      r_o_addr;
    logic [ffba_pkg::STAT_W-1:0]     r_o_status;
    ffba_pkg::t_entry                r_c, r_b, r_p;

    logic                            ram_we, ram_re;
    logic [ffba_pkg::IDX_W-1:0]      ram_waddr, ram_raddr;
    ffba_pkg::t_entry                ram_wdata, rd;

    logic [ffba_pkg::NEED_W-1:0]     in_need;
    logic [WW-1:0]                   w_need, total_raw, total;
    ffba_pkg::t_entry                new_ent, split_ent;
    logic [ffba_pkg::SIZE_W-1:0]     fwd_size, bwd_size;
    logic                            can_load;

    ffba_ram #(
        .WIDTH ($bits(ffba_pkg::t_entry)),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    always_comb begin
        in_need   = (ffba_pkg::NEED_W'(i_request_bytes) + N_ALIGNM) & ~N_ALIGNM;
        w_need    = WW'(r_need);
        // chunk = header plus size, page rounded, at least one chunk
        total_raw = (W_HDR + w_need + W_PAGEM) & ~W_PAGEM;
        total     = (total_raw < W_CHUNK) ? W_CHUNK : total_raw;

        new_ent.off  = ffba_pkg::OFF_W'(r_top);
        new_ent.size = ffba_pkg::SIZE_W'(total - W_HDR);
        new_ent.next = ffba_pkg::NIL;

        split_ent.off  = ffba_pkg::OFF_W'(WW'(r_c.off) + W_HDR + w_need);
        split_ent.size = ffba_pkg::SIZE_W'(WW'(r_c.size) - w_need - W_HDR);
        split_ent.next = r_c.next;

        fwd_size = ffba_pkg::SIZE_W'(WW'(r_b.size) + W_HDR + WW'(rd.size));
        bwd_size = ffba_pkg::SIZE_W'(WW'(r_p.size) + W_HDR + WW'(r_b.size));
        can_load = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        o_stat.cmd_free  = r_cmd;
        o_stat.req_zero  = r_req_zero;
        o_stat.addr_null = (r_addr == '0);
        o_stat.cur_end   = (r_cur >= ffba_pkg::NIL) || (r_steps == ffba_pkg::NIL);
        o_stat.fit       = r_is_free[r_cur[ffba_pkg::IDX_W-1:0]] &&
                           (WW'(rd.size) >= w_need);
        o_stat.scan_hit  = !r_in_use[r_i];
        o_stat.scan_last = (r_i == ffba_pkg::LAST_IDX);
        o_stat.new_ok    = (WW'(r_top) + total) <= W_HEAP;
        o_stat.head_nil  = (r_head >= ffba_pkg::NIL);
        o_stat.tail_more = (r_steps < ffba_pkg::NIL) && (rd.next < ffba_pkg::NIL);
        o_stat.split_ok  = WW'(r_c.size) >= (w_need + W_HDR + W_ALIGN);
        o_stat.look_hit  = r_in_use[r_i] && ((WW'(rd.off) + W_HDR) == WW'(r_addr));
        o_stat.look_last = (r_i == ffba_pkg::LAST_IDX);
        o_stat.fwd_stop  = (r_b.next >= ffba_pkg::NIL) || (r_steps == ffba_pkg::NIL) ||
                           !r_is_free[r_b.next[ffba_pkg::IDX_W-1:0]];
        // neighbor must touch in memory and not open a new chunk
        o_stat.fwd_touch = !r_starts[r_b.next[ffba_pkg::IDX_W-1:0]] &&
                           ((WW'(r_b.off) + W_HDR + WW'(r_b.size)) == WW'(rd.off));
        o_stat.bwd_stop  = (r_cur >= ffba_pkg::NIL) ||
                           (r_cur == ffba_pkg::PTR_W'(r_blk)) ||
                           (r_steps == ffba_pkg::NIL);
        o_stat.bwd_merge = (r_cur == ffba_pkg::PTR_W'(r_blk)) &&
                           (r_prev < ffba_pkg::NIL) &&
                           r_is_free[r_prev[ffba_pkg::IDX_W-1:0]] &&
                           !r_starts[r_blk] &&
                           ((WW'(r_p.off) + W_HDR + WW'(r_p.size)) == WW'(r_b.off));
        o_stat.can_load  = can_load;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = new_ent;
        ram_re    = 1'b0;
        ram_raddr = r_i;
        case (i_cmd.op)
            ffba_pkg::OP_NEW_CHUNK: begin
                ram_we = 1'b1;
            end
            ffba_pkg::OP_TAIL_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail[ffba_pkg::IDX_W-1:0];
                ram_wdata = '{off: rd.off, size: rd.size, next: r_cur};
            end
            ffba_pkg::OP_SPLIT_W1: begin
                ram_we    = 1'b1;
                ram_wdata = split_ent;
            end
            ffba_pkg::OP_SPLIT_W2: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[ffba_pkg::IDX_W-1:0];
                ram_wdata = '{off: r_c.off, size: ffba_pkg::SIZE_W'(r_need),
                              next: ffba_pkg::PTR_W'(r_i)};
            end
            ffba_pkg::OP_FWD_MERGE: begin
                ram_we    = 1'b1;
                ram_waddr = r_blk;
                ram_wdata = '{off: r_b.off, size: fwd_size, next: rd.next};
            end
            ffba_pkg::OP_BWD_MERGE: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev[ffba_pkg::IDX_W-1:0];
                ram_wdata = '{off: r_p.off, size: bwd_size, next: r_b.next};
            end
            ffba_pkg::OP_WALK_RD, ffba_pkg::OP_BWD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur[ffba_pkg::IDX_W-1:0];
            end
            ffba_pkg::OP_TAIL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_tail[ffba_pkg::IDX_W-1:0];
            end
            ffba_pkg::OP_LOOK_RD: begin
                ram_re = 1'b1;
            end
            ffba_pkg::OP_FWD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_b.next[ffba_pkg::IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // control state: flags, list head, region top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_is_free <= '0;
            r_starts  <= '0;
            r_head    <= ffba_pkg::NIL;
            r_top     <= '0;
        end else begin
            case (i_cmd.op)
                ffba_pkg::OP_NEW_CHUNK: begin
                    r_in_use[r_i]  <= 1'b1;
                    r_is_free[r_i] <= 1'b1;
                    r_starts[r_i]  <= 1'b1;
                    r_top          <= ffba_pkg::SIZE_W'(WW'(r_top) + total);
                    if (r_head >= ffba_pkg::NIL) begin
                        r_head <= ffba_pkg::PTR_W'(r_i);
                    end
                end
                ffba_pkg::OP_SPLIT_W1: begin
                    r_in_use[r_i]  <= 1'b1;
                    r_is_free[r_i] <= 1'b1;
                    r_starts[r_i]  <= 1'b0;
                end
                ffba_pkg::OP_GRANT: begin
                    r_is_free[r_cur[ffba_pkg::IDX_W-1:0]] <= 1'b0;
                end
                ffba_pkg::OP_LOOK_HIT: begin
                    r_is_free[r_i] <= 1'b1;
                end
                ffba_pkg::OP_FWD_MERGE: begin
                    r_in_use[r_b.next[ffba_pkg::IDX_W-1:0]] <= 1'b0;
                end
                ffba_pkg::OP_BWD_MERGE: begin
                    r_in_use[r_blk] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffba_pkg::OP_ACCEPT: begin
                r_cmd        <= i_command;
                r_req_zero   <= (i_request_bytes == '0);
                r_addr       <= i_free_address;
                r_need       <= in_need;
                r_cur        <= r_head;
                r_steps      <= '0;
                r_i          <= '0;
                r_res_addr   <= '0;
                r_res_status <= ffba_pkg::ST_OK;
            end
            ffba_pkg::OP_RES_IGNORED: r_res_status <= ffba_pkg::ST_IGNORED;
            ffba_pkg::OP_RES_OOM:     r_res_status <= ffba_pkg::ST_OOM;
            ffba_pkg::OP_RES_UNKNOWN: r_res_status <= ffba_pkg::ST_UNKNOWN;
            ffba_pkg::OP_WALK_NEXT: begin
                r_cur   <= rd.next;
                r_steps <= r_steps + 1'b1;
            end
            ffba_pkg::OP_WALK_HIT:   r_c <= rd;
            ffba_pkg::OP_SCAN_START: r_i <= '0;
            ffba_pkg::OP_SCAN_STEP:  r_i <= r_i + 1'b1;
            ffba_pkg::OP_NEW_CHUNK: begin
                r_c     <= new_ent;
                r_cur   <= ffba_pkg::PTR_W'(r_i);
                r_tail  <= r_head;
                r_steps <= '0;
            end
            ffba_pkg::OP_TAIL_NEXT: begin
                r_tail  <= rd.next;
                r_steps <= r_steps + 1'b1;
            end
            ffba_pkg::OP_SPLIT_W2: begin
                r_c.size <= ffba_pkg::SIZE_W'(r_need);
                r_c.next <= ffba_pkg::PTR_W'(r_i);
            end
            ffba_pkg::OP_GRANT: r_res_addr <= ffba_pkg::OFF_W'(WW'(r_c.off) + W_HDR);
            ffba_pkg::OP_LOOK_NEXT: r_i <= r_i + 1'b1;
            ffba_pkg::OP_LOOK_HIT: begin
                r_blk   <= r_i;
                r_b     <= rd;
                r_steps <= '0;
            end
            ffba_pkg::OP_FWD_MERGE: begin
                r_b.size <= fwd_size;
                r_b.next <= rd.next;
                r_steps  <= r_steps + 1'b1;
            end
            ffba_pkg::OP_BWD_INIT: begin
                r_cur   <= r_head;
                r_prev  <= ffba_pkg::NIL;
                r_steps <= '0;
            end
            ffba_pkg::OP_BWD_NEXT: begin
                r_prev  <= r_cur;
                r_p     <= rd;
                r_cur   <= rd.next;
                r_steps <= r_steps + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == ffba_pkg::OP_RES_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ffba_pkg::OP_RES_LOAD) begin
            r_o_addr   <= r_res_addr;
            r_o_status <= r_res_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_address = r_o_addr;
    assign o_status          = r_o_status;

endmodule

`default_nettype wire

/* hdl/ffba_ctrl.sv */
// allocator sequencer: walks, scans and merges, one datapath op per cycle
// depends on ffba_pkg
`default_nettype none

module ffba_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ffba_pkg::t_dp_stat i_stat,
    output ffba_pkg::t_dp_cmd       o_cmd
);

    ffba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_IDLE:
                if (i_in_valid) n_state = ffba_pkg::S_DECODE;
            ffba_pkg::S_DECODE: begin
                if (i_stat.cmd_free) begin
                    n_state = i_stat.addr_null ? ffba_pkg::S_RESULT : ffba_pkg::S_LOOK_RD;
                end else begin
                    n_state = i_stat.req_zero ? ffba_pkg::S_RESULT : ffba_pkg::S_WALK_RD;
                end
            end
            ffba_pkg::S_WALK_RD:
                n_state = i_stat.cur_end ? ffba_pkg::S_NEW_SCAN : ffba_pkg::S_WALK_CHK;
            ffba_pkg::S_WALK_CHK:
                n_state = i_stat.fit ? ffba_pkg::S_SPLIT_CHK : ffba_pkg::S_WALK_RD;
            ffba_pkg::S_NEW_SCAN: begin
                if (i_stat.scan_hit) begin
                    if (!i_stat.new_ok)       n_state = ffba_pkg::S_RESULT;
                    else if (i_stat.head_nil) n_state = ffba_pkg::S_SPLIT_CHK;
                    else                      n_state = ffba_pkg::S_TAIL_RD;
                end else if (i_stat.scan_last) begin
                    n_state = ffba_pkg::S_RESULT;
                end
            end
            ffba_pkg::S_TAIL_RD:  n_state = ffba_pkg::S_TAIL_CHK;
            ffba_pkg::S_TAIL_CHK:
                n_state = i_stat.tail_more ? ffba_pkg::S_TAIL_RD : ffba_pkg::S_SPLIT_CHK;
            ffba_pkg::S_SPLIT_CHK:
                n_state = i_stat.split_ok ? ffba_pkg::S_SPLIT_SCAN : ffba_pkg::S_GRANT;
            ffba_pkg::S_SPLIT_SCAN: begin
                if (i_stat.scan_hit)       n_state = ffba_pkg::S_SPLIT_W2;
                else if (i_stat.scan_last) n_state = ffba_pkg::S_GRANT;
            end
            ffba_pkg::S_SPLIT_W2: n_state = ffba_pkg::S_GRANT;
            ffba_pkg::S_GRANT:    n_state = ffba_pkg::S_RESULT;
            ffba_pkg::S_LOOK_RD:  n_state = ffba_pkg::S_LOOK_CHK;
            ffba_pkg::S_LOOK_CHK: begin
                if (i_stat.look_hit)       n_state = ffba_pkg::S_FWD;
                else if (i_stat.look_last) n_state = ffba_pkg::S_RESULT;
                else                       n_state = ffba_pkg::S_LOOK_RD;
            end
            ffba_pkg::S_FWD:
                n_state = i_stat.fwd_stop ? ffba_pkg::S_BWD : ffba_pkg::S_FWD_CHK;
            ffba_pkg::S_FWD_CHK:
                n_state = i_stat.fwd_touch ? ffba_pkg::S_FWD : ffba_pkg::S_BWD;
            ffba_pkg::S_BWD:
                n_state = i_stat.bwd_stop ? ffba_pkg::S_BWD_END : ffba_pkg::S_BWD_CHK;
            ffba_pkg::S_BWD_CHK:  n_state = ffba_pkg::S_BWD;
            ffba_pkg::S_BWD_END:  n_state = ffba_pkg::S_RESULT;
            ffba_pkg::S_RESULT:
                if (i_stat.can_load) n_state = ffba_pkg::S_IDLE;
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = ffba_pkg::OP_NONE;
        o_in_stall = (r_state != ffba_pkg::S_IDLE);
        case (r_state)
            ffba_pkg::S_IDLE:
                if (i_in_valid) o_cmd.op = ffba_pkg::OP_ACCEPT;
            ffba_pkg::S_DECODE: begin
                if (i_stat.cmd_free ? i_stat.addr_null : i_stat.req_zero) begin
                    o_cmd.op = ffba_pkg::OP_RES_IGNORED;
                end
            end
            ffba_pkg::S_WALK_RD:
                o_cmd.op = i_stat.cur_end ? ffba_pkg::OP_SCAN_START : ffba_pkg::OP_WALK_RD;
            ffba_pkg::S_WALK_CHK:
                o_cmd.op = i_stat.fit ? ffba_pkg::OP_WALK_HIT : ffba_pkg::OP_WALK_NEXT;
            ffba_pkg::S_NEW_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.op = i_stat.new_ok ? ffba_pkg::OP_NEW_CHUNK : ffba_pkg::OP_RES_OOM;
                end else if (i_stat.scan_last) begin
                    o_cmd.op = ffba_pkg::OP_RES_OOM;
                end else begin
                    o_cmd.op = ffba_pkg::OP_SCAN_STEP;
                end
            end
            ffba_pkg::S_TAIL_RD: o_cmd.op = ffba_pkg::OP_TAIL_RD;
            ffba_pkg::S_TAIL_CHK:
                o_cmd.op = i_stat.tail_more ? ffba_pkg::OP_TAIL_NEXT : ffba_pkg::OP_TAIL_LINK;
            ffba_pkg::S_SPLIT_CHK:
                if (i_stat.split_ok) o_cmd.op = ffba_pkg::OP_SCAN_START;
            ffba_pkg::S_SPLIT_SCAN: begin
                // table full: the whole block is granted
                if (i_stat.scan_hit)        o_cmd.op = ffba_pkg::OP_SPLIT_W1;
                else if (!i_stat.scan_last) o_cmd.op = ffba_pkg::OP_SCAN_STEP;
            end
            ffba_pkg::S_SPLIT_W2: o_cmd.op = ffba_pkg::OP_SPLIT_W2;
            ffba_pkg::S_GRANT:    o_cmd.op = ffba_pkg::OP_GRANT;
            ffba_pkg::S_LOOK_RD:  o_cmd.op = ffba_pkg::OP_LOOK_RD;
            ffba_pkg::S_LOOK_CHK: begin
                if (i_stat.look_hit)       o_cmd.op = ffba_pkg::OP_LOOK_HIT;
                else if (i_stat.look_last) o_cmd.op = ffba_pkg::OP_RES_UNKNOWN;
                else                       o_cmd.op = ffba_pkg::OP_LOOK_NEXT;
            end
            ffba_pkg::S_FWD:
                o_cmd.op = i_stat.fwd_stop ? ffba_pkg::OP_BWD_INIT : ffba_pkg::OP_FWD_RD;
            ffba_pkg::S_FWD_CHK:
                o_cmd.op = i_stat.fwd_touch ? ffba_pkg::OP_FWD_MERGE : ffba_pkg::OP_BWD_INIT;
            ffba_pkg::S_BWD:
                if (!i_stat.bwd_stop) o_cmd.op = ffba_pkg::OP_BWD_RD;
            ffba_pkg::S_BWD_CHK: o_cmd.op = ffba_pkg::OP_BWD_NEXT;
            ffba_pkg::S_BWD_END:
                if (i_stat.bwd_merge) o_cmd.op = ffba_pkg::OP_BWD_MERGE;
            ffba_pkg::S_RESULT:
                if (i_stat.can_load) o_cmd.op = ffba_pkg::OP_RES_LOAD;
            default: o_cmd.op = ffba_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/first_fit_block_allocator.sv */
// first-fit block allocator top level: sequencer plus datapath
// depends on ffba_pkg, ffba_ctrl, ffba_datapath
//
// Handles one request at a time: o_in_stall is high from acceptance until
// the result has been placed in the output register, which may still be
// waiting to be taken when the next request is accepted. Block offsets,
// sizes and links live in one single-port-read table RAM with registered
// read, so every list step is a read state followed by a check state;
// the in-use, free and chunk-start flags are registers. An allocate walks
// the block list until a fit is found; if none fits, a scan of the table
// finds an unused entry and a tail walk links the new chunk; a split adds
// another scan of up to MAX_BLOCKS table entries. A free searches the
// table entries for the address, merges forward, and walks the list to
// find the predecessor. No clearing pass is needed after reset.
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_command,
    input  wire logic [ffba_pkg::REQ_W-1:0]    i_request_bytes,
    input  wire logic [ffba_pkg::OFF_W-1:0]    i_free_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [ffba_pkg::OFF_W-1:0]    o_payload_address,
    output logic      [ffba_pkg::STAT_W-1:0]   o_status
);

    ffba_pkg::t_dp_cmd  dp_cmd;
    ffba_pkg::t_dp_stat dp_stat;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ffba_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_command         (i_command),
        .i_request_bytes   (i_request_bytes),
        .i_free_address    (i_free_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_payload_address (o_payload_address),
        .o_status          (o_status)
    );

endmodule

`default_nettype wire

/* hdl/ffba_checker.sv */
// port-level checks for the first-fit block allocator, bound to the top level
// depends on ffba_pkg
`default_nettype none

module ffba_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [ffba_pkg::OFF_W-1:0]    o_payload_address,
    input wire logic [ffba_pkg::STAT_W-1:0]   o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while busy");

    a_addr_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_address != '0) |-> (o_status == ffba_pkg::ST_OK))
        else $error("address granted with error status");

    a_error_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ffba_pkg::ST_OK) |-> (o_payload_address == '0))
        else $error("error status with nonzero address");

endmodule

bind first_fit_block_allocator ffba_checker u_chk (.*);

`default_nettype wire

/* tb/tb_first_fit_block_allocator.sv */
// testbench for first_fit_block_allocator: sends allocate and free requests,
// predicts each result with a behavioral block list, and checks every result
// depends on ffba_pkg and the first_fit_block_allocator rtl
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_command = ffba_pkg::CMD_ALLOC;
    logic [ffba_pkg::REQ_W-1:0]    i_request_bytes = '0;
    logic [ffba_pkg::OFF_W-1:0]    i_free_address = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [ffba_pkg::OFF_W-1:0]    o_payload_address;
    logic [ffba_pkg::STAT_W-1:0]   o_status;

    first_fit_block_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [ffba_pkg::OFF_W-1:0]  addr;
        logic [ffba_pkg::STAT_W-1:0] stat;
    } t_grant;

    // block list copy
    logic [ffba_pkg::OFF_W-1:0]  blk_off   [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::SIZE_W-1:0] blk_size  [ffba_pkg::MAX_BLOCKS];
    bit                          blk_free  [ffba_pkg::MAX_BLOCKS];
    bit                          blk_chunk [ffba_pkg::MAX_BLOCKS];
    bit                          blk_used  [ffba_pkg::MAX_BLOCKS];
    int                          blk_next  [ffba_pkg::MAX_BLOCKS];
    int                          list_head = ffba_pkg::MAX_BLOCKS;
    longint                      heap_top = 0;

    t_grant      grants_due[$];
    logic [19:0] live_addrs[$];
    logic [19:0] dead_addrs[$];
    int          errors = 0;
    int          checked = 0;
    int          idle_cycles = 0;
    int          n_ok = 0, n_ign = 0, n_oom = 0, n_unk = 0;
    bit          allow_idle = 1'b1;

    function automatic int unused_slot();
        for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++)
            if (!blk_used[i]) return i;
        return ffba_pkg::MAX_BLOCKS;
    endfunction

    function automatic bit adjoins(int a, int b);
        if (blk_chunk[b]) return 1'b0;
        return longint'(blk_off[a]) + ffba_pkg::HEADER_BYTES + blk_size[a] ==
               longint'(blk_off[b]);
    endfunction

    function automatic t_grant predict_alloc(longint req);
        longint need, total;
        int cur, steps, idx, tail;
        t_grant g;
        g = '0;
        if (req == 0) begin
            g.stat = ffba_pkg::ST_IGNORED;
            return g;
        end
        need = ((req + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES) *
               ffba_pkg::ALIGN_BYTES;
        cur = list_head;
        for (steps = 0; cur < ffba_pkg::MAX_BLOCKS && steps < ffba_pkg::MAX_BLOCKS;
             steps++) begin
            if (blk_free[cur] && longint'(blk_size[cur]) >= need) break;
            cur = blk_next[cur];
        end
        if (cur >= ffba_pkg::MAX_BLOCKS || steps >= ffba_pkg::MAX_BLOCKS) begin
            total = ((ffba_pkg::HEADER_BYTES + need + ffba_pkg::PAGE_BYTES - 1) /
                     ffba_pkg::PAGE_BYTES) * ffba_pkg::PAGE_BYTES;
            if (total < ffba_pkg::CHUNK_BYTES) total = ffba_pkg::CHUNK_BYTES;
            idx = unused_slot();
            if (idx >= ffba_pkg::MAX_BLOCKS || heap_top + total > ffba_pkg::HEAP_BYTES) begin
                g.stat = ffba_pkg::ST_OOM;
                return g;
            end
            blk_used[idx] = 1;
            blk_off[idx] = heap_top[ffba_pkg::OFF_W-1:0];
            blk_size[idx] = ffba_pkg::SIZE_W'(total - ffba_pkg::HEADER_BYTES);
            blk_free[idx] = 1;
            blk_chunk[idx] = 1;
            blk_next[idx] = ffba_pkg::MAX_BLOCKS;
            heap_top += total;
            if (list_head >= ffba_pkg::MAX_BLOCKS) begin
                list_head = idx;
            end else begin
                tail = list_head;
                for (steps = 0; steps < ffba_pkg::MAX_BLOCKS &&
                     blk_next[tail] < ffba_pkg::MAX_BLOCKS; steps++)
                    tail = blk_next[tail];
                blk_next[tail] = idx;
            end
            cur = idx;
        end
        if (longint'(blk_size[cur]) >=
            need + ffba_pkg::HEADER_BYTES + ffba_pkg::ALIGN_BYTES) begin
            idx = unused_slot();
            if (idx < ffba_pkg::MAX_BLOCKS) begin
                blk_used[idx] = 1;
                blk_off[idx] = ffba_pkg::OFF_W'(longint'(blk_off[cur]) +
                                                ffba_pkg::HEADER_BYTES + need);
                blk_size[idx] = ffba_pkg::SIZE_W'(longint'(blk_size[cur]) - need -
                                                  ffba_pkg::HEADER_BYTES);
                blk_free[idx] = 1;
                blk_chunk[idx] = 0;
                blk_next[idx] = blk_next[cur];
                blk_size[cur] = ffba_pkg::SIZE_W'(need);
                blk_next[cur] = idx;
            end
        end
        blk_free[cur] = 0;
        g.addr = ffba_pkg::OFF_W'(longint'(blk_off[cur]) + ffba_pkg::HEADER_BYTES);
        g.stat = ffba_pkg::ST_OK;
        return g;
    endfunction

    function automatic t_grant predict_free(logic [ffba_pkg::OFF_W-1:0] addr);
        int blk, nx, prv, cur, steps;
        t_grant g;
        g = '0;
        blk = ffba_pkg::MAX_BLOCKS;
        prv = ffba_pkg::MAX_BLOCKS;
        if (addr == 0) begin
            g.stat = ffba_pkg::ST_IGNORED;
            return g;
        end
        for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++)
            if (blk_used[i] &&
                longint'(blk_off[i]) + ffba_pkg::HEADER_BYTES == longint'(addr)) begin
                blk = i;
                break;
            end
        if (blk >= ffba_pkg::MAX_BLOCKS) begin
            g.stat = ffba_pkg::ST_UNKNOWN;
            return g;
        end
        blk_free[blk] = 1;
        for (steps = 0; steps < ffba_pkg::MAX_BLOCKS; steps++) begin
            nx = blk_next[blk];
            if (nx >= ffba_pkg::MAX_BLOCKS || !blk_free[nx] || !adjoins(blk, nx)) break;
            blk_size[blk] = ffba_pkg::SIZE_W'(longint'(blk_size[blk]) +
                                              ffba_pkg::HEADER_BYTES + blk_size[nx]);
            blk_next[blk] = blk_next[nx];
            blk_used[nx] = 0;
        end
        cur = list_head;
        for (steps = 0; cur < ffba_pkg::MAX_BLOCKS && cur != blk &&
             steps < ffba_pkg::MAX_BLOCKS; steps++) begin
            prv = cur;
            cur = blk_next[cur];
        end
        if (cur == blk && prv < ffba_pkg::MAX_BLOCKS && blk_free[prv] &&
            adjoins(prv, blk)) begin
            blk_size[prv] = ffba_pkg::SIZE_W'(longint'(blk_size[prv]) +
                                              ffba_pkg::HEADER_BYTES + blk_size[blk]);
            blk_next[prv] = blk_next[blk];
            blk_used[blk] = 0;
        end
        g.stat = ffba_pkg::ST_OK;
        return g;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 checked, what, got, want);
    endtask

    task automatic send_request(logic cmd, logic [ffba_pkg::REQ_W-1:0] req,
                                logic [ffba_pkg::OFF_W-1:0] addr);
        t_grant g;
        if (allow_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        i_command = cmd;
        i_request_bytes = req;
        i_free_address = addr;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == ffba_pkg::CMD_ALLOC) begin
            g = predict_alloc(longint'(req));
            if (g.stat == ffba_pkg::ST_OK) live_addrs.push_back(g.addr);
        end else begin
            g = predict_free(addr);
        end
        grants_due.push_back(g);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic release_live(int pick);
        logic [ffba_pkg::OFF_W-1:0] a;
        a = live_addrs[pick];
        live_addrs.delete(pick);
        dead_addrs.push_back(a);
        if (dead_addrs.size() > 32) void'(dead_addrs.pop_front());
        send_request(ffba_pkg::CMD_FREE, '0, a);
    endtask

    task automatic wait_drained();
        wait (grants_due.size() == 0);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            idle_cycles <= 0;
            checked++;
            if (grants_due.size() == 0) begin
                errors++;
                $display("unexpected result: addr 0x%0h status %0d",
                         o_payload_address, o_status);
            end else begin
                t_grant w;
                w = grants_due.pop_front();
                if (o_payload_address !== w.addr)
                    report("payload_address", o_payload_address, w.addr);
                if (o_status !== w.stat) report("status", o_status, w.stat);
                case (w.stat)
                    ffba_pkg::ST_OK:      n_ok++;
                    ffba_pkg::ST_IGNORED: n_ign++;
                    ffba_pkg::ST_OOM:     n_oom++;
                    default:              n_unk++;
                endcase
            end
        end else if (i_rst_n && i_in_valid && !o_in_stall) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", idle_cycles);
            $display("first_fit_block_allocator test failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (allow_idle && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
        end
    end

    task automatic test_directed();
        send_request(ffba_pkg::CMD_ALLOC, '0, '0);              // zero size
        send_request(ffba_pkg::CMD_FREE, '0, '0);               // null free
        send_request(ffba_pkg::CMD_ALLOC, 21'd1, '0);
        send_request(ffba_pkg::CMD_ALLOC, 21'd16, '0);
        send_request(ffba_pkg::CMD_ALLOC, 21'd17, '0);
        send_request(ffba_pkg::CMD_FREE, '0, 20'd12345);        // unknown address
        send_request(ffba_pkg::CMD_FREE, '0, 20'hFFFFF);
        send_request(ffba_pkg::CMD_ALLOC, 21'd1048576, '0);     // as large as the heap
        send_request(ffba_pkg::CMD_ALLOC, 21'h1FFFFF, '0);
        send_request(ffba_pkg::CMD_ALLOC, 21'd65504, '0);       // exactly one chunk
        send_request(ffba_pkg::CMD_ALLOC, 21'd65505, '0);       // spills to a bigger chunk
        release_live(1);
        release_live(0);                              // merges with the following block
        send_request(ffba_pkg::CMD_FREE, '0, dead_addrs[0]);    // double free
        release_live(0);
        release_live(0);                              // chunk neighbors must not merge
        release_live(0);
        send_request(ffba_pkg::CMD_ALLOC, 21'd40000, '0);
        release_live(0);
    endtask

    task automatic test_table_full();
        // many small grants exhaust the table, so splits get skipped
        for (int i = 0; i < 70; i++)
            send_request(ffba_pkg::CMD_ALLOC, 21'($urandom_range(1, 64)), '0);
        while (live_addrs.size() > 0) release_live($urandom_range(0, live_addrs.size() - 1));
    endtask

    task automatic random_request();
        int r;
        logic [ffba_pkg::REQ_W-1:0] sz;
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 75 && live_addrs.size() == 0)) begin
            case ($urandom_range(0, 9))
                0:       sz = ffba_pkg::REQ_W'($urandom_range(20000, 300000));
                1:       sz = ffba_pkg::REQ_W'($urandom);
                default: sz = ffba_pkg::REQ_W'($urandom_range(1, 3000));
            endcase
            send_request(ffba_pkg::CMD_ALLOC, sz, '0);
        end else if (live_addrs.size() > 0 && (r < 82 || live_addrs.size() > 40)) begin
            release_live($urandom_range(0, live_addrs.size() - 1));
        end else if (r < 88 && dead_addrs.size() > 0) begin
            send_request(ffba_pkg::CMD_FREE, '0,
                         dead_addrs[$urandom_range(0, dead_addrs.size() - 1)]);
        end else if (r < 94) begin
            send_request(ffba_pkg::CMD_FREE, '0, ffba_pkg::OFF_W'($urandom));
        end else if (r < 97) begin
            send_request(ffba_pkg::CMD_ALLOC, '0, ffba_pkg::OFF_W'($urandom));
        end else begin
            send_request(ffba_pkg::CMD_FREE, ffba_pkg::REQ_W'($urandom), '0);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            random_request();
            if (i % 300 == 150) wait_drained();      // let the block run dry
        end
    endtask

    task automatic test_no_idle(int count);
        wait_drained();
        allow_idle = 1'b0;
        for (int i = 0; i < count; i++) random_request();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random(1100);
        test_no_idle(250);
        wait_drained();
        repeat (400) @(negedge i_clk);
        $display("checked %0d results: %0d ok, %0d ignored, %0d out of memory, %0d unknown",
                 checked, n_ok, n_ign, n_oom, n_unk);
        if (errors == 0 && grants_due.size() == 0) begin
            $display("first_fit_block_allocator test passed");
        end else begin
            $display("first_fit_block_allocator test failed");
        end
        $finish;
    end

endmodule
